### design/siq_pkg.sv
package siq_pkg;

  localparam int SegDepth = 16;
  localparam int SegCount = 3;
  localparam int PortLimit = 3;

  localparam int PcW = 64;
  localparam int ClassW = 4;
  localparam int SegW = 2;
  localparam int CtrW = 64;
  localparam int CapW = 8;
  localparam int WidthW = 2;
  localparam int DefaultWidth = 2;
  localparam int IdxW = (SegDepth > 1) ? $clog2(SegDepth) : 1;
  localparam int FillW = $clog2(SegDepth + 1);
  localparam int AddrW = $clog2(SegCount * SegDepth);
  localparam int CntW = $clog2(PortLimit + 1);
  localparam int SlotW = ClassW + PcW;

  localparam logic [ClassW-1:0] ClassLoad = 4'd4;
  localparam logic [ClassW-1:0] ClassStore = 4'd5;
  localparam logic [ClassW-1:0] ClassFpu = 4'd6;
  localparam logic [ClassW-1:0] ClassMul = 4'd7;
  localparam logic [ClassW-1:0] ClassDiv = 4'd8;

  localparam logic [SegW-1:0] SegInt = 2'd0;
  localparam logic [SegW-1:0] SegMem = 2'd1;
  localparam logic [SegW-1:0] SegFpu = 2'd2;

  localparam logic FuncEnqueue = 1'b0;
  localparam logic FuncIssue = 1'b1;

  function automatic logic [SegW-1:0] segment_of(input logic [ClassW-1:0] cls);
    logic [SegW-1:0] seg;
    unique case (cls)
      ClassLoad, ClassStore: seg = SegMem;
      ClassFpu, ClassMul, ClassDiv: seg = SegFpu;
      default: seg = SegInt;
    endcase
    return seg;
  endfunction

  function automatic logic [SegW-1:0] next_seg(input logic [SegW-1:0] seg);
    return (seg == SegFpu) ? SegInt : SegW'(seg + 1'b1);
  endfunction

  function automatic logic [AddrW-1:0] slot_addr(input logic [SegW-1:0] seg,
                                                 input logic [IdxW-1:0] idx);
    return AddrW'(AddrW'(seg) * AddrW'(SegDepth) + AddrW'(idx));
  endfunction

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] idx);
    return (idx == IdxW'(SegDepth - 1)) ? '0 : IdxW'(idx + 1'b1);
  endfunction

endpackage

### design/siq_ram.sv
module siq_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/segmented_issue_queue.sv
// Issue queue with three FIFO segments (integer, memory, fpu) that share one
// slot memory. A word on the input channel (in_valid_i/in_ready_o) is either
// an enqueue (func_i low: entry_pc_i and unit_class_i) or an issue request
// (func_i high: issue_cap_i, where zero selects the configured default).
// Result words leave on out_valid_o/out_ready_i. An enqueue gives one word;
// an issue gives one word per issued entry, or one empty word, with last_o
// on the final one. The running totals reflect the whole request.
// Enqueue: the result word is registered in the cycle after acceptance.
// Issue: after acceptance, each issued entry passes through StRead, the
// registered read of the slot memory, and StEmit, which loads the output
// register; an issue takes up to three entries.
// The block takes one request at a time and accepts the next one only when
// the output register is free or is being emptied in the same cycle.
// A stalled receiver holds the result word and pauses the issue sequence.
// Reset empties all segments, clears the counters and the round-robin
// pointer and sets the default issue width to two; the slot memory itself
// is not cleared, since a slot is only read after it has been written.
// cfg_we_i/cfg_wdata_i write the default width; write it only while idle.
module segmented_issue_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [siq_pkg::WidthW-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              func_i,
  input  logic [siq_pkg::PcW-1:0]           entry_pc_i,
  input  logic [siq_pkg::ClassW-1:0]        unit_class_i,
  input  logic [siq_pkg::CapW-1:0]          issue_cap_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              accepted_o,
  output logic                              issue_valid_o,
  output logic [siq_pkg::PcW-1:0]           issued_pc_o,
  output logic [siq_pkg::ClassW-1:0]        issued_class_o,
  output logic [siq_pkg::SegW-1:0]          issued_segment_o,
  output logic                              last_o,
  output logic [siq_pkg::CtrW-1:0]          rejected_total_o,
  output logic [siq_pkg::CtrW-1:0]          enqueued_total_o,
  output logic [siq_pkg::CtrW-1:0]          issued_total_o
);

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StEmit
  } state_e;

  state_e state_q;

  logic [siq_pkg::IdxW-1:0]   head_q [siq_pkg::SegCount];
  logic [siq_pkg::IdxW-1:0]   tail_q [siq_pkg::SegCount];
  logic [siq_pkg::FillW-1:0]  fill_q [siq_pkg::SegCount];
  logic [siq_pkg::SegW-1:0]   rot_q;
  logic [siq_pkg::SegW-1:0]   probe_q;
  logic [siq_pkg::SegW-1:0]   cur_seg_q;
  logic [siq_pkg::CntW-1:0]   total_q;
  logic [siq_pkg::CntW-1:0]   emitted_q;
  logic [siq_pkg::WidthW-1:0] dflt_q;
  logic [siq_pkg::CtrW-1:0]   rej_ctr_q;
  logic [siq_pkg::CtrW-1:0]   enq_ctr_q;
  logic [siq_pkg::CtrW-1:0]   iss_ctr_q;

  logic                       out_valid_q;
  logic                       accepted_q;
  logic                       issue_valid_q;
  logic [siq_pkg::PcW-1:0]    pc_q;
  logic [siq_pkg::ClassW-1:0] class_q;
  logic [siq_pkg::SegW-1:0]   seg_out_q;
  logic                       last_q;

  logic                       out_free;
  logic                       in_fire;
  logic [siq_pkg::SegCount-1:0] nonempty;
  logic [siq_pkg::CntW-1:0]   avail;
  logic [siq_pkg::CapW-1:0]   cap_sel;
  logic [siq_pkg::CntW-1:0]   cap_eff;
  logic [siq_pkg::CntW-1:0]   total_d;
  logic [siq_pkg::SegW:0]     rot_sum;
  logic [siq_pkg::SegW-1:0]   rot_d;
  logic [siq_pkg::SegW-1:0]   enq_seg;
  logic                       enq_ok;
  logic [siq_pkg::SegW-1:0]   cand1;
  logic [siq_pkg::SegW-1:0]   cand2;
  logic [siq_pkg::SegW-1:0]   pick;
  logic                       ram_we;
  logic                       ram_re;
  logic [siq_pkg::AddrW-1:0]  ram_waddr;
  logic [siq_pkg::AddrW-1:0]  ram_raddr;
  logic [siq_pkg::SlotW-1:0]  ram_rdata;
  logic                       emit_last;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    avail = '0;
    for (int s = 0; s < siq_pkg::SegCount; s++) begin
      nonempty[s] = (fill_q[s] != '0);
      avail = siq_pkg::CntW'(avail + siq_pkg::CntW'(nonempty[s]));
    end
  end

  assign cap_sel = (issue_cap_i == '0) ? siq_pkg::CapW'(dflt_q) : issue_cap_i;
  assign cap_eff = (cap_sel > siq_pkg::CapW'(siq_pkg::PortLimit)) ?
                   siq_pkg::CntW'(siq_pkg::PortLimit) : siq_pkg::CntW'(cap_sel);
  // Each non-empty segment yields at most one entry, so the issue count is
  // known before the first result word goes out.
  assign total_d = (cap_eff < avail) ? cap_eff : avail;

  assign rot_sum = (siq_pkg::SegW+1)'(rot_q) + (siq_pkg::SegW+1)'(total_d);
  assign rot_d   = (rot_sum >= (siq_pkg::SegW+1)'(siq_pkg::SegCount)) ?
                   siq_pkg::SegW'(rot_sum - (siq_pkg::SegW+1)'(siq_pkg::SegCount)) :
                   siq_pkg::SegW'(rot_sum);

  assign enq_seg = siq_pkg::segment_of(unit_class_i);
  assign enq_ok  = (fill_q[enq_seg] != siq_pkg::FillW'(siq_pkg::SegDepth));

  assign cand1 = siq_pkg::next_seg(probe_q);
  assign cand2 = siq_pkg::next_seg(cand1);

  always_comb begin
    priority if (nonempty[probe_q]) begin
      pick = probe_q;
    end else if (nonempty[cand1]) begin
      pick = cand1;
    end else begin
      pick = cand2;
    end
  end

  assign ram_we    = in_fire && (func_i == siq_pkg::FuncEnqueue) && enq_ok;
  assign ram_waddr = siq_pkg::slot_addr(enq_seg, tail_q[enq_seg]);
  assign ram_re    = (state_q == StRead);
  assign ram_raddr = siq_pkg::slot_addr(pick, head_q[pick]);
  assign emit_last = (siq_pkg::CntW'(emitted_q + 1'b1) == total_q);

  siq_ram #(
    .Width(siq_pkg::SlotW),
    .Depth(siq_pkg::SegCount * siq_pkg::SegDepth)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i({unit_class_i, entry_pc_i}),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      for (int s = 0; s < siq_pkg::SegCount; s++) begin
        head_q[s] <= '0;
        tail_q[s] <= '0;
        fill_q[s] <= '0;
      end
      rot_q         <= '0;
      probe_q       <= '0;
      cur_seg_q     <= '0;
      total_q       <= '0;
      emitted_q     <= '0;
      dflt_q        <= siq_pkg::WidthW'(siq_pkg::DefaultWidth);
      rej_ctr_q     <= '0;
      enq_ctr_q     <= '0;
      iss_ctr_q     <= '0;
      out_valid_q   <= 1'b0;
      accepted_q    <= 1'b0;
      issue_valid_q <= 1'b0;
      pc_q          <= '0;
      class_q       <= '0;
      seg_out_q     <= '0;
      last_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dflt_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            if (func_i == siq_pkg::FuncEnqueue) begin
              if (enq_ok) begin
                tail_q[enq_seg] <= siq_pkg::next_idx(tail_q[enq_seg]);
                fill_q[enq_seg] <= siq_pkg::FillW'(fill_q[enq_seg] + 1'b1);
                enq_ctr_q       <= enq_ctr_q + 1'b1;
              end else begin
                rej_ctr_q <= rej_ctr_q + 1'b1;
              end
              out_valid_q   <= 1'b1;
              accepted_q    <= enq_ok;
              issue_valid_q <= 1'b0;
              pc_q          <= '0;
              class_q       <= '0;
              seg_out_q     <= '0;
              last_q        <= 1'b1;
            end else begin
              rot_q     <= rot_d;
              iss_ctr_q <= iss_ctr_q + siq_pkg::CtrW'(total_d);
              probe_q   <= rot_q;
              total_q   <= total_d;
              emitted_q <= '0;
              if (total_d == '0) begin
                out_valid_q   <= 1'b1;
                accepted_q    <= 1'b0;
                issue_valid_q <= 1'b0;
                pc_q          <= '0;
                class_q       <= '0;
                seg_out_q     <= '0;
                last_q        <= 1'b1;
              end else begin
                state_q <= StRead;
              end
            end
          end
        end
        StRead: begin
          head_q[pick] <= siq_pkg::next_idx(head_q[pick]);
          fill_q[pick] <= siq_pkg::FillW'(fill_q[pick] - 1'b1);
          cur_seg_q    <= pick;
          probe_q      <= siq_pkg::next_seg(pick);
          state_q      <= StEmit;
        end
        StEmit: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            accepted_q    <= 1'b0;
            issue_valid_q <= 1'b1;
            pc_q          <= ram_rdata[siq_pkg::PcW-1:0];
            class_q       <= ram_rdata[siq_pkg::SlotW-1:siq_pkg::PcW];
            seg_out_q     <= cur_seg_q;
            last_q        <= emit_last;
            emitted_q     <= siq_pkg::CntW'(emitted_q + 1'b1);
            state_q       <= emit_last ? StIdle : StRead;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = accepted_q;
  assign issue_valid_o    = issue_valid_q;
  assign issued_pc_o      = pc_q;
  assign issued_class_o   = class_q;
  assign issued_segment_o = seg_out_q;
  assign last_o           = last_q;
  assign rejected_total_o = rej_ctr_q;
  assign enqueued_total_o = enq_ctr_q;
  assign issued_total_o   = iss_ctr_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q[0] <= siq_pkg::FillW'(siq_pkg::SegDepth)) &&
    (fill_q[1] <= siq_pkg::FillW'(siq_pkg::SegDepth)) &&
    (fill_q[2] <= siq_pkg::FillW'(siq_pkg::SegDepth)))
    else $error("segment fill count above depth");

  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> (emitted_q < total_q))
    else $error("issue sequence ran past its count");

  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(accepted_o && issue_valid_o))
    else $error("result word is both enqueue and issue");

  a_enq_no_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (func_i == siq_pkg::FuncEnqueue)) |=> $stable(iss_ctr_q))
    else $error("enqueue changed the issue counter");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> nonempty[pick])
    else $error("issue read from an empty segment");

endmodule
